FILE: hw/rtl/dac_pkg.sv
package dac_pkg;

   localparam int CMD_W = 3;

   localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CMP = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RND = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   localparam logic signed [1:0] CMP_LESS    = -2'sd1;
   localparam logic signed [1:0] CMP_EQUAL   = 2'sd0;
   localparam logic signed [1:0] CMP_GREATER = 2'sd1;

   localparam logic RND_FRACTION = 1'b0;
   localparam logic RND_WHOLE    = 1'b1;

   // One request as it travels through the front of the pipeline.
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [63:0]      a_value;
      logic [31:0]      a_fraction;
      logic             a_valid;
      logic [63:0]      b_value;
      logic [31:0]      b_fraction;
      logic             b_valid;
      logic             same_currency;
      logic [31:0]      divisor;
   } item_type;

   // Sideband that rides along the divider cells. When done is set, the
   // amount and status fields already hold the final result.
   typedef struct packed {
      logic             done;
      logic [CMD_W-1:0] command;
      logic             rnd_mode;
      logic [63:0]      value;
      logic [31:0]      fraction;
      logic             valid;
      logic [1:0]       status;
      logic signed [1:0] cmp;
   } side_type;

endpackage

FILE: hw/rtl/decimal_amount_arithmetic_unit.sv
// Throughput: one item per cycle; the 64-cell and clog2(FRAC_BASE)-cell
// divider chains each take a new item every cycle.
// Reset is synchronous and clears the pipeline valid bits; busy is high only
// while reset is. The receiver cannot stall, and every item gives one result.
module decimal_amount_arithmetic_unit #(
   parameter int unsigned FRAC_BASE       = 100000000,
   parameter int unsigned MAX_VALUE_SHIFT = 52
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_command,
   input  logic [63:0]       req_a_value,
   input  logic [31:0]       req_a_fraction,
   input  logic              req_a_valid,
   input  logic [63:0]       req_b_value,
   input  logic [31:0]       req_b_fraction,
   input  logic              req_b_valid,
   input  logic              req_same_currency,
   input  logic [31:0]       req_divisor,
   output logic              rsp_strobe,
   output logic [63:0]       rsp_out_value,
   output logic [31:0]       rsp_out_fraction,
   output logic              rsp_out_valid,
   output logic [1:0]        rsp_status,
   output logic signed [1:0] rsp_compare_result
);

   localparam int          QBITS   = $clog2(FRAC_BASE);
   localparam int          LATENCY = 71 + QBITS;
   localparam logic [31:0] BASE    = 32'(FRAC_BASE);
   localparam logic [63:0] LIMIT   = 64'd1 << MAX_VALUE_SHIFT;

   // Input register.
   logic              in_valid_ff;
   dac_pkg::item_type in_ff;
   logic              accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      in_ff.command       <= req_command;
      in_ff.a_value       <= req_a_value;
      in_ff.a_fraction    <= req_a_fraction;
      in_ff.a_valid       <= req_a_valid;
      in_ff.b_value       <= req_b_value;
      in_ff.b_fraction    <= req_b_fraction;
      in_ff.b_valid       <= req_b_valid;
      in_ff.same_currency <= req_same_currency;
      in_ff.divisor       <= req_divisor;
   end

   // Normalization of both amounts, three stages.
   logic [63:0] na_value, nb_value;
   logic [31:0] na_fraction, nb_fraction;
   logic        na_ok, nb_ok;

   dac_norm #(.FRAC_BASE(FRAC_BASE)) u_norm_a (
      .clock      (clock),
      .value_i    (in_ff.a_value),
      .fraction_i (in_ff.a_fraction),
      .value_o    (na_value),
      .fraction_o (na_fraction),
      .ok_o       (na_ok)
   );

   dac_norm #(.FRAC_BASE(FRAC_BASE)) u_norm_b (
      .clock      (clock),
      .value_i    (in_ff.b_value),
      .fraction_i (in_ff.b_fraction),
      .value_o    (nb_value),
      .fraction_o (nb_fraction),
      .ok_o       (nb_ok)
   );

   logic              vp_ff [3];
   dac_pkg::item_type ip_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff[0] <= 1'b0;
         vp_ff[1] <= 1'b0;
         vp_ff[2] <= 1'b0;
      end else begin
         vp_ff[0] <= in_valid_ff;
         vp_ff[1] <= vp_ff[0];
         vp_ff[2] <= vp_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      ip_ff[0] <= in_ff;
      ip_ff[1] <= ip_ff[0];
      ip_ff[2] <= ip_ff[1];
   end

   // Operation stage: add, subtract and compare finish here; divide and
   // round down are set up for the divider chain.
   dac_pkg::item_type it;
   dac_pkg::side_type side_d_in;
   logic [63:0]       dividend_in, divisor_in;
   logic              norm_ok;
   logic [64:0]       sum_v;
   logic [32:0]       sum_f;
   logic [63:0]       add_v;
   logic [31:0]       add_f;
   logic              add_err;
   logic              borrow;
   logic [64:0]       diff_v;
   logic [31:0]       sub_f;
   logic signed [1:0] cmp_res;

   assign it = ip_ff[2];

   always_comb begin
      norm_ok = it.a_valid & it.b_valid & it.same_currency & na_ok & nb_ok;

      sum_v   = {1'b0, na_value} + {1'b0, nb_value};
      sum_f   = {1'b0, na_fraction} + {1'b0, nb_fraction};
      add_err = sum_v[64] | (sum_v[63:0] > LIMIT);
      if (sum_f >= {1'b0, BASE}) begin
         add_f = sum_f[31:0] - BASE;
         add_v = sum_v[63:0] + 64'd1;
      end else begin
         add_f = sum_f[31:0];
         add_v = sum_v[63:0];
      end

      borrow = na_fraction < nb_fraction;
      diff_v = {1'b0, na_value} - {1'b0, nb_value} - {64'd0, borrow};
      sub_f  = borrow ? (na_fraction + BASE - nb_fraction) : (na_fraction - nb_fraction);

      if (na_value == nb_value) begin
         if (na_fraction < nb_fraction) begin
            cmp_res = dac_pkg::CMP_LESS;
         end else if (na_fraction > nb_fraction) begin
            cmp_res = dac_pkg::CMP_GREATER;
         end else begin
            cmp_res = dac_pkg::CMP_EQUAL;
         end
      end else if (na_value < nb_value) begin
         cmp_res = dac_pkg::CMP_LESS;
      end else begin
         cmp_res = dac_pkg::CMP_GREATER;
      end

      side_d_in.done     = 1'b1;
      side_d_in.command  = it.command;
      side_d_in.rnd_mode = dac_pkg::RND_FRACTION;
      side_d_in.value    = 64'd0;
      side_d_in.fraction = 32'd0;
      side_d_in.valid    = 1'b0;
      side_d_in.status   = dac_pkg::ST_ERR;
      side_d_in.cmp      = dac_pkg::CMP_EQUAL;
      dividend_in        = 64'd0;
      divisor_in         = 64'd0;

      unique case (it.command)
         dac_pkg::CMD_ADD: begin
            if (norm_ok && !add_err) begin
               side_d_in.value    = add_v;
               side_d_in.fraction = add_f;
               side_d_in.valid    = 1'b1;
               side_d_in.status   = dac_pkg::ST_OK;
            end
         end
         dac_pkg::CMD_SUB: begin
            if (norm_ok && !diff_v[64]) begin
               side_d_in.value    = diff_v[63:0];
               side_d_in.fraction = sub_f;
               side_d_in.valid    = 1'b1;
               side_d_in.status   = (diff_v[63:0] == 64'd0 && sub_f == 32'd0) ?
                                    dac_pkg::ST_ZERO : dac_pkg::ST_OK;
            end
         end
         dac_pkg::CMD_CMP: begin
            if (norm_ok) begin
               side_d_in.status = dac_pkg::ST_OK;
               side_d_in.cmp    = cmp_res;
            end
         end
         dac_pkg::CMD_DIV: begin
            if (it.divisor != 32'd0 && it.a_valid && na_ok) begin
               side_d_in.done     = 1'b0;
               side_d_in.fraction = na_fraction;
               side_d_in.valid    = 1'b1;
               side_d_in.status   = dac_pkg::ST_OK;
               dividend_in        = na_value;
               divisor_in         = {32'd0, it.divisor};
            end
         end
         dac_pkg::CMD_RND: begin
            side_d_in.value    = it.a_value;
            side_d_in.fraction = it.a_fraction;
            side_d_in.valid    = it.a_valid;
            if (it.b_fraction != 32'd0 && it.b_value != 64'd0) begin
               side_d_in.status = dac_pkg::ST_ERR;
            end else if (it.b_fraction == 32'd0 && it.b_value == 64'd0) begin
               side_d_in.status = dac_pkg::ST_ZERO;
            end else if (it.b_fraction != 32'd0) begin
               side_d_in.done     = 1'b0;
               side_d_in.rnd_mode = dac_pkg::RND_FRACTION;
               side_d_in.status   = dac_pkg::ST_OK;
               dividend_in        = {32'd0, it.a_fraction};
               divisor_in         = {32'd0, it.b_fraction};
            end else begin
               side_d_in.done     = 1'b0;
               side_d_in.rnd_mode = dac_pkg::RND_WHOLE;
               side_d_in.status   = dac_pkg::ST_OK;
               dividend_in        = it.a_value;
               divisor_in         = it.b_value;
            end
         end
         default: begin
            side_d_in.status = dac_pkg::ST_ERR;
         end
      endcase
   end

   logic              d_valid_ff;
   dac_pkg::side_type side_d_ff;
   logic [63:0]       dividend_ff, divisor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= vp_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      side_d_ff   <= side_d_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
   end

   // First divider chain: 64 quotient bits.
   logic              c1_valid [65];
   logic [63:0]       c1_rem   [65];
   logic [63:0]       c1_dq    [65];
   logic [63:0]       c1_div   [65];
   dac_pkg::side_type c1_side  [65];

   assign c1_valid[0] = d_valid_ff;
   assign c1_rem[0]   = 64'd0;
   assign c1_dq[0]    = dividend_ff;
   assign c1_div[0]   = divisor_ff;
   assign c1_side[0]  = side_d_ff;

   for (genvar i = 0; i < 64; i++) begin : g_chain1
      dac_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (c1_valid[i]),
         .rem_i   (c1_rem[i]),
         .dq_i    (c1_dq[i]),
         .div_i   (c1_div[i]),
         .side_i  (c1_side[i]),
         .valid_o (c1_valid[i+1]),
         .rem_o   (c1_rem[i+1]),
         .dq_o    (c1_dq[i+1]),
         .div_o   (c1_div[i+1]),
         .side_o  (c1_side[i+1])
      );
   end

   // Middle stage: round down finishes; divide scales its remainder.
   dac_pkg::side_type s1, side_m_in;
   logic [63:0]       n2_in;
   logic [63:0]       rem_whole;
   logic [31:0]       rem_frac;

   assign s1        = c1_side[64];
   assign rem_whole = c1_rem[64];
   assign rem_frac  = c1_rem[64][31:0];
   assign n2_in     = (64'(rem_frac) * 64'(BASE)) + 64'(s1.fraction);

   always_comb begin
      side_m_in = s1;
      if (!s1.done) begin
         if (s1.command == dac_pkg::CMD_DIV) begin
            side_m_in.value = c1_dq[64];
         end else if (s1.rnd_mode == dac_pkg::RND_FRACTION) begin
            side_m_in.done = 1'b1;
            if (rem_frac == 32'd0) begin
               side_m_in.status = dac_pkg::ST_ZERO;
            end else begin
               side_m_in.fraction = s1.fraction - rem_frac;
            end
         end else begin
            side_m_in.done = 1'b1;
            if (rem_whole == 64'd0) begin
               side_m_in.status = dac_pkg::ST_ZERO;
            end else begin
               side_m_in.value    = s1.value - rem_whole;
               side_m_in.fraction = 32'd0;
            end
         end
      end
   end

   logic              m_valid_ff;
   dac_pkg::side_type side_m_ff;
   logic [63:0]       n2_ff, div_m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= c1_valid[64];
      end
   end

   always_ff @(posedge clock) begin
      side_m_ff <= side_m_in;
      n2_ff     <= n2_in;
      div_m_ff  <= c1_div[64];
   end

   // Second divider chain: the fraction quotient is below FRAC_BASE, so
   // QBITS steps suffice and the upper part starts as the remainder.
   logic              c2_valid [QBITS+1];
   logic [63:0]       c2_rem   [QBITS+1];
   logic [63:0]       c2_dq    [QBITS+1];
   logic [63:0]       c2_div   [QBITS+1];
   dac_pkg::side_type c2_side  [QBITS+1];

   assign c2_valid[0] = m_valid_ff;
   assign c2_rem[0]   = n2_ff >> QBITS;
   assign c2_dq[0]    = n2_ff << (64 - QBITS);
   assign c2_div[0]   = div_m_ff;
   assign c2_side[0]  = side_m_ff;

   for (genvar j = 0; j < QBITS; j++) begin : g_chain2
      dac_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (c2_valid[j]),
         .rem_i   (c2_rem[j]),
         .dq_i    (c2_dq[j]),
         .div_i   (c2_div[j]),
         .side_i  (c2_side[j]),
         .valid_o (c2_valid[j+1]),
         .rem_o   (c2_rem[j+1]),
         .dq_o    (c2_dq[j+1]),
         .div_o   (c2_div[j+1]),
         .side_o  (c2_side[j+1])
      );
   end

   // Output register.
   dac_pkg::side_type s2;
   logic [31:0]       fin_frac;
   logic              strobe_ff;
   logic [63:0]       value_ff;
   logic [31:0]       fraction_ff;
   logic              valid_ff;
   logic [1:0]        status_ff;
   logic signed [1:0] cmp_ff;

   assign s2       = c2_side[QBITS];
   assign fin_frac = s2.done ? s2.fraction : 32'(c2_dq[QBITS][QBITS-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= c2_valid[QBITS];
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= s2.valid ? s2.value : 64'd0;
      fraction_ff <= s2.valid ? fin_frac : 32'd0;
      valid_ff    <= s2.valid;
      status_ff   <= s2.status;
      cmp_ff      <= s2.cmp;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_out_value      = value_ff;
   assign rsp_out_fraction   = fraction_ff;
   assign rsp_out_valid      = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_compare_result = cmp_ff;

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("result strobe missing after a transfer");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_out_valid) |-> (rsp_out_value == 64'd0 &&
                                          rsp_out_fraction == 32'd0))
      else $error("invalid result carries a nonzero amount");

   a_cmp_only : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_compare_result != dac_pkg::CMP_EQUAL) |->
      (!rsp_out_valid && rsp_status == dac_pkg::ST_OK))
      else $error("compare result with an amount or a bad status");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");
`endif

endmodule

FILE: hw/rtl/dac_norm.sv
module dac_norm #(
   parameter int unsigned FRAC_BASE = 100000000
) (
   input  logic        clock,
   input  logic [63:0] value_i,
   input  logic [31:0] fraction_i,
   output logic [63:0] value_o,
   output logic [31:0] fraction_o,
   output logic        ok_o
);

   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / FRAC_BASE);
   localparam logic [31:0] BASE  = 32'(FRAC_BASE);

   logic [63:0] val1_ff, val2_ff, val3_ff;
   logic [31:0] frac1_ff, q2_ff, r2_ff, frac3_ff;
   logic [63:0] prod1_ff;
   logic        ok3_ff;

   logic [31:0] q2_in, r2_in, q3, r3;
   logic [64:0] sum3;

   // The reciprocal estimate is at most one below the true quotient.
   assign q2_in = prod1_ff[63:32];
   assign r2_in = frac1_ff - (q2_in * BASE);

   always_comb begin
      if (r2_ff >= BASE) begin
         q3 = q2_ff + 32'd1;
         r3 = r2_ff - BASE;
      end else begin
         q3 = q2_ff;
         r3 = r2_ff;
      end
      sum3 = {1'b0, val2_ff} + {33'd0, q3};
   end

   always_ff @(posedge clock) begin
      val1_ff  <= value_i;
      frac1_ff <= fraction_i;
      prod1_ff <= 64'(fraction_i) * 64'(RECIP);
      val2_ff  <= val1_ff;
      q2_ff    <= q2_in;
      r2_ff    <= r2_in;
      val3_ff  <= sum3[63:0];
      frac3_ff <= r3;
      ok3_ff   <= ~sum3[64];
   end

   assign value_o    = val3_ff;
   assign fraction_o = frac3_ff;
   assign ok_o       = ok3_ff;

endmodule

FILE: hw/rtl/dac_cell.sv
module dac_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_i,
   input  logic [63:0]       rem_i,
   input  logic [63:0]       dq_i,
   input  logic [63:0]       div_i,
   input  dac_pkg::side_type side_i,
   output logic              valid_o,
   output logic [63:0]       rem_o,
   output logic [63:0]       dq_o,
   output logic [63:0]       div_o,
   output dac_pkg::side_type side_o
);

   logic              valid_ff;
   logic [63:0]       rem_ff, dq_ff, div_ff;
   dac_pkg::side_type side_ff;

   logic [64:0] trial, diff;
   logic        fits;

   // One restoring step: the next dividend bit enters the partial
   // remainder and one quotient bit enters at the bottom of dq.
   always_comb begin
      trial = {rem_i, dq_i[63]};
      diff  = trial - {1'b0, div_i};
      fits  = ~diff[64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= fits ? diff[63:0] : trial[63:0];
      dq_ff   <= {dq_i[62:0], fits};
      div_ff  <= div_i;
      side_ff <= side_i;
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign dq_o    = dq_ff;
   assign div_o   = div_ff;
   assign side_o  = side_ff;

endmodule

FILE: tb/sv/decimal_amount_arithmetic_unit_tb.sv
`timescale 1ns / 100ps

module decimal_amount_arithmetic_unit_tb;

   localparam longint unsigned FBASE = 100000000;
   localparam int unsigned VSHIFT = 52;
   localparam logic [2:0] CMD_UNKNOWN = 3'd7;

   typedef struct {
      logic [63:0]       value;
      logic [31:0]       fraction;
      logic              valid;
      logic [1:0]        status;
      logic signed [1:0] cmp;
   } amount_result_type;

   // Brings carries out of the fraction; returns 0 when the whole part overflows.
   function automatic bit fold_carry(inout logic [63:0] v, inout logic [63:0] f);
      logic [63:0] q;
      q = f / FBASE;
      if (q > 64'hFFFF_FFFF_FFFF_FFFF - v) return 0;
      v = v + q;
      f = f % FBASE;
      return 1;
   endfunction

   function automatic amount_result_type compute_amount(dac_pkg::item_type it);
      amount_result_type r;
      logic [63:0] av, af, bv, bf, sv, sf, rem, delta;
      logic [63:0] d;
      bit ok;
      av = it.a_value; af = 64'(it.a_fraction);
      bv = it.b_value; bf = 64'(it.b_fraction);
      d = 64'(it.divisor);
      r.value = 0; r.fraction = 0; r.valid = 0; r.status = dac_pkg::ST_ERR;
      r.cmp = dac_pkg::CMP_EQUAL;
      case (it.command)
         dac_pkg::CMD_ADD, dac_pkg::CMD_SUB, dac_pkg::CMD_CMP: begin
            ok = it.a_valid && it.b_valid && it.same_currency;
            if (ok) ok = fold_carry(av, af);
            if (ok) ok = fold_carry(bv, bf);
            if (!ok) return r;
            if (it.command == dac_pkg::CMD_ADD) begin
               sv = av + bv;
               sf = af + bf;
               if (sv < av || sv > (64'd1 << VSHIFT)) return r;
               if (!fold_carry(sv, sf)) return r;
               r.value = sv; r.fraction = sf[31:0]; r.valid = 1; r.status = dac_pkg::ST_OK;
            end else if (it.command == dac_pkg::CMD_SUB) begin
               if (af < bf) begin
                  if (av == 0) return r;
                  af = af + FBASE;
                  av = av - 1;
               end
               if (av < bv) return r;
               av = av - bv;
               af = af - bf;
               r.value = av; r.fraction = af[31:0]; r.valid = 1;
               r.status = (av == 0 && af == 0) ? dac_pkg::ST_ZERO : dac_pkg::ST_OK;
            end else begin
               r.status = dac_pkg::ST_OK;
               if (av == bv)
                  r.cmp = (af < bf) ? dac_pkg::CMP_LESS :
                          (af > bf) ? dac_pkg::CMP_GREATER : dac_pkg::CMP_EQUAL;
               else
                  r.cmp = (av < bv) ? dac_pkg::CMP_LESS : dac_pkg::CMP_GREATER;
            end
         end
         dac_pkg::CMD_DIV: begin
            if (d == 0 || !it.a_valid) return r;
            if (!fold_carry(av, af)) return r;
            if (d != 1) begin
               rem = av % d;
               av = av / d;
               rem = rem * FBASE + af;
               af = rem / d;
               if (!fold_carry(av, af)) return r;
            end
            r.value = av; r.fraction = af[31:0]; r.valid = 1; r.status = dac_pkg::ST_OK;
         end
         dac_pkg::CMD_RND: begin
            r.status = dac_pkg::ST_OK;
            if (bf != 0 && bv != 0) r.status = dac_pkg::ST_ERR;
            else if (bf == 0 && bv == 0) r.status = dac_pkg::ST_ZERO;
            else if (bf != 0) begin
               delta = af % bf;
               if (delta == 0) r.status = dac_pkg::ST_ZERO;
               else af = af - delta;
            end else begin
               delta = av % bv;
               if (delta == 0) r.status = dac_pkg::ST_ZERO;
               else begin
                  av = av - delta;
                  af = 0;
               end
            end
            r.valid = it.a_valid;
            if (r.valid) begin
               r.value = av; r.fraction = af[31:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   class amount_scoreboard;
      amount_result_type pending[$];
      int errors;
      int checked;

      function void note_request(dac_pkg::item_type it);
         pending.push_back(compute_amount(it));
      endfunction

      function void check_result(amount_result_type got);
         amount_result_type exp;
         if (pending.size() == 0) begin
            $display("%0t: result with none expected, value %h", $time, got.value);
            errors++;
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.value !== exp.value) begin
            $display("%0t: out_value expected %h actual %h", $time, exp.value, got.value);
            errors++;
         end
         if (got.fraction !== exp.fraction) begin
            $display("%0t: out_fraction expected %h actual %h", $time, exp.fraction,
                     got.fraction);
            errors++;
         end
         if (got.valid !== exp.valid) begin
            $display("%0t: out_valid expected %b actual %b", $time, exp.valid, got.valid);
            errors++;
         end
         if (got.status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            errors++;
         end
         if (got.cmp !== exp.cmp) begin
            $display("%0t: compare_result expected %0d actual %0d", $time, exp.cmp, got.cmp);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic [2:0]        req_command = dac_pkg::CMD_ADD;
   logic [63:0]       req_a_value = 0;
   logic [31:0]       req_a_fraction = 0;
   logic              req_a_valid = 0;
   logic [63:0]       req_b_value = 0;
   logic [31:0]       req_b_fraction = 0;
   logic              req_b_valid = 0;
   logic              req_same_currency = 0;
   logic [31:0]       req_divisor = 0;
   logic              rsp_strobe;
   logic [63:0]       rsp_out_value;
   logic [31:0]       rsp_out_fraction;
   logic              rsp_out_valid;
   logic [1:0]        rsp_status;
   logic signed [1:0] rsp_compare_result;

   amount_scoreboard board = new();
   int transfers;

   decimal_amount_arithmetic_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      amount_result_type got;
      if (!reset && rsp_strobe) begin
         got.value = rsp_out_value;
         got.fraction = rsp_out_fraction;
         got.valid = rsp_out_valid;
         got.status = rsp_status;
         got.cmp = rsp_compare_result;
         board.check_result(got);
      end
   end

   // Holds one request on the ports until the block takes it. Start stays high
   // when back-to-back transfers follow, so it is never lowered and raised in one step.
   task automatic send_request(dac_pkg::item_type it, bit keep_start);
      req_command <= it.command;
      req_a_value <= it.a_value;
      req_a_fraction <= it.a_fraction;
      req_a_valid <= it.a_valid;
      req_b_value <= it.b_value;
      req_b_fraction <= it.b_fraction;
      req_b_valid <= it.b_valid;
      req_same_currency <= it.same_currency;
      req_divisor <= it.divisor;
      start <= 1;
      do @(posedge clock); while (busy);
      board.note_request(it);
      transfers++;
      if (!keep_start) start <= 0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pick_whole();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
         2: return 64'($urandom_range(0, 1000));
         3: return (64'd1 << VSHIFT) - 64'($urandom_range(0, 3)) + 64'($urandom_range(0, 3));
         4: return rand64() >> $urandom_range(12, 40);
         default: return rand64();
      endcase
   endfunction

   function automatic logic [31:0] pick_fraction();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 32'($urandom_range(0, 32'(FBASE - 1)));
         2: return 32'(FBASE - 1);
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic dac_pkg::item_type random_request();
      dac_pkg::item_type it;
      it.command = 3'($urandom_range(0, 12) < 12 ? $urandom_range(0, 4) : $urandom_range(5, 7));
      it.a_value = pick_whole();
      it.a_fraction = pick_fraction();
      it.b_value = pick_whole();
      it.b_fraction = pick_fraction();
      // Mostly well-formed pairs so the arithmetic paths are reached.
      it.a_valid = $urandom_range(0, 9) != 0;
      it.b_valid = $urandom_range(0, 9) != 0;
      it.same_currency = $urandom_range(0, 9) != 0;
      case ($urandom_range(0, 5))
         0: it.divisor = 0;
         1: it.divisor = 1;
         2: it.divisor = 32'hFFFF_FFFF;
         3: it.divisor = 32'($urandom_range(2, 100));
         default: it.divisor = $urandom();
      endcase
      if (it.command == dac_pkg::CMD_SUB && $urandom_range(0, 3) == 0) begin
         it.b_value = it.a_value;
         it.b_fraction = it.a_fraction;
      end
      if (it.command == dac_pkg::CMD_RND) begin
         case ($urandom_range(0, 4))
            0: begin
               it.b_value = 0;
               it.b_fraction = 32'($urandom_range(1, 32'(FBASE)));
            end
            1: begin it.b_value = 64'($urandom_range(1, 1000)); it.b_fraction = 0; end
            2: begin it.b_value = rand64(); it.b_fraction = 0; end
            3: begin it.b_value = 0; it.b_fraction = 0; end
            default: ;
         endcase
      end
      return it;
   endfunction

   function automatic dac_pkg::item_type make_request(logic [2:0] c, logic [63:0] av,
                                                      logic [31:0] af, logic [63:0] bv,
                                                      logic [31:0] bf, logic [31:0] d);
      dac_pkg::item_type it;
      it.command = c;
      it.a_value = av; it.a_fraction = af; it.a_valid = 1;
      it.b_value = bv; it.b_fraction = bf; it.b_valid = 1;
      it.same_currency = 1;
      it.divisor = d;
      return it;
   endfunction

   initial begin
      dac_pkg::item_type directed[$];
      dac_pkg::item_type it;
      int burst;
      int gap = 1;
      localparam logic [63:0] MAXV = 64'hFFFF_FFFF_FFFF_FFFF;
      localparam logic [63:0] LIM = 64'd1 << VSHIFT;

      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed.push_back(make_request(dac_pkg::CMD_ADD, 5, 60000000, 7, 50000000, 0));
      directed.push_back(make_request(dac_pkg::CMD_ADD, LIM, 0, 0, 99999999, 0));
      directed.push_back(make_request(dac_pkg::CMD_ADD, LIM, 50000000, 0, 50000000, 0));
      directed.push_back(make_request(dac_pkg::CMD_ADD, MAXV, 0, 1, 0, 0));
      directed.push_back(make_request(dac_pkg::CMD_ADD, MAXV, 32'hFFFF_FFFF, 0, 0, 0));
      directed.push_back(make_request(dac_pkg::CMD_SUB, 10, 20, 10, 20, 0));
      directed.push_back(make_request(dac_pkg::CMD_SUB, 0, 10, 0, 20, 0));
      directed.push_back(make_request(dac_pkg::CMD_SUB, 3, 10, 1, 20, 0));
      directed.push_back(make_request(dac_pkg::CMD_SUB, 1, 0, 2, 0, 0));
      directed.push_back(make_request(dac_pkg::CMD_CMP, 4, 5, 4, 6, 0));
      directed.push_back(make_request(dac_pkg::CMD_CMP, 4, 5, 4, 5, 0));
      directed.push_back(make_request(dac_pkg::CMD_CMP, MAXV, 0, 0, 0, 0));
      directed.push_back(make_request(dac_pkg::CMD_DIV, 100, 0, 0, 0, 0));
      directed.push_back(make_request(dac_pkg::CMD_DIV, 100, 250000000, 0, 0, 1));
      directed.push_back(make_request(dac_pkg::CMD_DIV, MAXV, 32'hFFFF_FFFF, 0, 0, 3));
      directed.push_back(make_request(dac_pkg::CMD_DIV, 7, 1, 0, 0, 32'hFFFF_FFFF));
      directed.push_back(make_request(dac_pkg::CMD_RND, 9, 12345, 1, 100, 0));
      directed.push_back(make_request(dac_pkg::CMD_RND, 9, 12345, 0, 0, 0));
      directed.push_back(make_request(dac_pkg::CMD_RND, 9, 12300, 0, 100, 0));
      directed.push_back(make_request(dac_pkg::CMD_RND, 17, 500, 5, 0, 0));
      directed.push_back(make_request(dac_pkg::CMD_RND, 15, 500, 5, 0, 0));
      directed.push_back(make_request(CMD_UNKNOWN, 1, 1, 1, 1, 1));
      it = make_request(dac_pkg::CMD_ADD, 1, 1, 1, 1, 1); it.same_currency = 0;
      directed.push_back(it);
      it = make_request(dac_pkg::CMD_RND, 17, 500, 5, 0, 0); it.a_valid = 0;
      directed.push_back(it);
      it = make_request(dac_pkg::CMD_DIV, 17, 500, 0, 0, 4); it.a_valid = 0;
      directed.push_back(it);
      foreach (directed[i]) send_request(directed[i], i < directed.size() - 1);

      // Let every directed result drain before the random bursts begin.
      while (board.pending.size() != 0) @(posedge clock);

      while (transfers < 1625) begin
         burst = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) != 0) ? int'($urandom_range(1, 6)) : 0;
         for (int k = 0; k < burst; k++)
            send_request(random_request(), k < burst - 1 || gap == 0);
         if (gap != 0)
            repeat (gap) @(posedge clock);
      end
      // Without a closing gap the last burst left start high.
      if (gap == 0) start <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      $display("Sent %0d requests over all five commands and the unknown codes;", transfers);
      $display("checked %0d results including carry, limit and rounding cases.",
               board.checked);
      if (board.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/dac_pkg.sv
hw/rtl/dac_norm.sv
hw/rtl/dac_cell.sv
hw/rtl/decimal_amount_arithmetic_unit.sv
tb/sv/decimal_amount_arithmetic_unit_tb.sv
